// File: sv/tts_pkg.sv
`timescale 1ns / 1ps
// tts_pkg: shared types, constants and byte class helpers for the token splitter
// used by tts_lexer_core, tts_token_queue and text_token_splitter

package tts_pkg;

  localparam int unsigned POSITION_WIDTH_DEFAULT = 16;
  localparam int unsigned TOKEN_FIELD_WIDTH      = 16;
  localparam int unsigned TEXT_BYTE_WIDTH        = 8;
  localparam int unsigned RESULT_COUNT_WIDTH     = 2;

  localparam logic [TEXT_BYTE_WIDTH-1:0] QUOTE_BYTE = 8'h22;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_STRING = 2'd3
  } scan_mode_e;

  typedef struct packed {
    logic [TOKEN_FIELD_WIDTH-1:0] length;
    logic [TOKEN_FIELD_WIDTH-1:0] start;
  } token_t;

  // results produced by one accepted item, in order, slot 0 first
  typedef struct packed {
    logic [RESULT_COUNT_WIDTH-1:0] count;
    token_t                        tok1;
    token_t                        tok0;
  } tok_push_t;

  function automatic logic is_letter(logic [TEXT_BYTE_WIDTH-1:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(logic [TEXT_BYTE_WIDTH-1:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(logic [TEXT_BYTE_WIDTH-1:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

// File: sv/tts_lexer_core.sv
`timescale 1ns / 1ps
// tts_lexer_core: scan mode and position registers plus the per-byte token logic
// depends on tts_pkg

module tts_lexer_core #(
  parameter int unsigned POSITION_WIDTH = tts_pkg::POSITION_WIDTH_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   fire_i,
  input  logic [tts_pkg::TEXT_BYTE_WIDTH-1:0]    text_byte_i,
  input  logic                                   end_of_text_i,
  output tts_pkg::tok_push_t                     push_o
);
  import tts_pkg::*;

  localparam int unsigned EXT_WIDTH =
    (POSITION_WIDTH > TOKEN_FIELD_WIDTH) ? POSITION_WIDTH : TOKEN_FIELD_WIDTH;

  scan_mode_e                mode_q, mode_d;
  logic [POSITION_WIDTH-1:0] open_q, open_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;

  logic [POSITION_WIDTH-1:0] pos_next;
  logic                      is_let, is_dig, is_spc, is_quo;
  logic                      cont, close_prev, close_str, single, flush;
  scan_mode_e                mode_mid;
  logic [POSITION_WIDTH-1:0] open_mid;
  token_t                    tok_a, tok_b, tok_c;

  // saturate a position-wide value into a 16-bit field
  function automatic logic [TOKEN_FIELD_WIDTH-1:0] clamp_field(
    logic [POSITION_WIDTH-1:0] v
  );
    logic [EXT_WIDTH-1:0] ve;
    ve = EXT_WIDTH'(v);
    if ((ve >> TOKEN_FIELD_WIDTH) != '0) begin
      return '1;
    end
    return ve[TOKEN_FIELD_WIDTH-1:0];
  endfunction

  function automatic token_t make_token(
    logic [POSITION_WIDTH-1:0] s,
    logic [POSITION_WIDTH-1:0] e
  );
    logic [POSITION_WIDTH-1:0] len;
    token_t                    t;
    len = (e >= s) ? (e - s) : '0;
    if (len == '0) begin
      len = POSITION_WIDTH'(1);
    end
    t.start  = clamp_field(s);
    t.length = clamp_field(len);
    return t;
  endfunction

  assign pos_next = (&pos_q) ? pos_q : pos_q + POSITION_WIDTH'(1);

  assign is_let = is_letter(text_byte_i);
  assign is_dig = is_digit(text_byte_i);
  assign is_spc = is_space(text_byte_i);
  assign is_quo = (text_byte_i == QUOTE_BYTE);

  always_comb begin
    cont       = 1'b0;
    close_prev = 1'b0;
    close_str  = 1'b0;
    single     = 1'b0;
    mode_mid   = mode_q;
    open_mid   = open_q;
    case (mode_q)
      MODE_IDENT: begin
        cont = is_let || is_dig;
      end
      MODE_NUMBER: begin
        cont = is_dig;
      end
      MODE_STRING: begin
        cont = 1'b1;
      end
      default: begin
        cont = 1'b0;
      end
    endcase
    if ((mode_q == MODE_IDENT || mode_q == MODE_NUMBER) && !cont) begin
      close_prev = 1'b1;
      mode_mid   = MODE_IDLE;
    end
    if (mode_q == MODE_STRING && is_quo) begin
      close_str = 1'b1;
      mode_mid  = MODE_IDLE;
    end
    // byte not taken by an open token is handled as from idle
    if (!cont && !is_spc) begin
      if (is_let) begin
        mode_mid = MODE_IDENT;
        open_mid = pos_q;
      end else if (is_dig) begin
        mode_mid = MODE_NUMBER;
        open_mid = pos_q;
      end else if (is_quo) begin
        mode_mid = MODE_STRING;
        open_mid = pos_q;
      end else begin
        single = 1'b1;
      end
    end
    flush = end_of_text_i && (mode_mid != MODE_IDLE);
  end

  always_comb begin
    tok_a = make_token(open_q, close_str ? pos_next : pos_q);
    tok_b = make_token(pos_q, pos_next);
    tok_c = make_token(open_mid, pos_next);
  end

  // order: closed token, one-byte token, end-of-text flush; two at most
  always_comb begin
    push_o = '0;
    if (close_prev || close_str) begin
      push_o.tok0 = tok_a;
      if (single) begin
        push_o.tok1  = tok_b;
        push_o.count = RESULT_COUNT_WIDTH'(2);
      end else if (flush) begin
        push_o.tok1  = tok_c;
        push_o.count = RESULT_COUNT_WIDTH'(2);
      end else begin
        push_o.count = RESULT_COUNT_WIDTH'(1);
      end
    end else if (single) begin
      push_o.tok0  = tok_b;
      push_o.count = RESULT_COUNT_WIDTH'(1);
    end else if (flush) begin
      push_o.tok0  = tok_c;
      push_o.count = RESULT_COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    mode_d = mode_q;
    open_d = open_q;
    pos_d  = pos_q;
    if (fire_i) begin
      open_d = open_mid;
      if (end_of_text_i) begin
        mode_d = MODE_IDLE;
        pos_d  = '0;
      end else begin
        mode_d = mode_mid;
        pos_d  = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      open_q <= '0;
      pos_q  <= '0;
    end else begin
      mode_q <= mode_d;
      open_q <= open_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// File: sv/tts_token_queue.sv
`timescale 1ns / 1ps
// tts_token_queue: two-slot result register, one token out per cycle while ready
// depends on tts_pkg

module tts_token_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tts_pkg::tok_push_t  push_data_i,
  output logic                push_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tts_pkg::token_t     out_token_o,
  output logic                out_last_o
);
  import tts_pkg::*;

  logic [RESULT_COUNT_WIDTH-1:0] cnt_q, cnt_d;
  token_t                        slot0_q, slot0_d;
  token_t                        slot1_q, slot1_d;
  logic                          pop;

  assign out_valid_o  = (cnt_q != '0);
  assign out_token_o  = slot0_q;
  assign out_last_o   = (cnt_q == RESULT_COUNT_WIDTH'(1));
  assign pop          = out_valid_o && out_ready_i;
  // take a new item once the last pending token leaves
  assign push_ready_o = (cnt_q == '0) || (out_last_o && out_ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push_i) begin
      cnt_d   = push_data_i.count;
      slot0_d = push_data_i.tok0;
      slot1_d = push_data_i.tok1;
    end else if (pop) begin
      cnt_d   = cnt_q - RESULT_COUNT_WIDTH'(1);
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

// File: sv/text_token_splitter.sv
`timescale 1ns / 1ps
// text_token_splitter: streaming lexer, one text byte in, token start/length out
// depends on tts_pkg, tts_lexer_core and tts_token_queue
//
//   channel  | dir | tdata (low bit up)                   | tlast
//   ---------+-----+--------------------------------------+-------------
//   s_axis   | in  | text_byte[7:0]                       | end_of_text
//   m_axis   | out | token_start[15:0], token_length[31:16] | last_of_run
//
// one byte is taken per cycle while s_axis_tready is high; the byte's scan step is
// combinational from the mode/position registers into a two-slot result register
// a byte that yields at most one token does not hold the input by itself; a byte
// that yields two tokens holds the input until its second token leaves
// a byte's first token shows on the output in the cycle after the byte is taken
// reset puts the scanner in idle at position zero and empties the result slots
// output stalls back-pressure the input while any result token is still pending

module text_token_splitter #(
  parameter int unsigned POSITION_WIDTH = tts_pkg::POSITION_WIDTH_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input items
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [tts_pkg::TEXT_BYTE_WIDTH-1:0]    s_axis_tdata,  // text_byte
  input  logic                                   s_axis_tlast,  // end_of_text
  // result items
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [2*tts_pkg::TOKEN_FIELD_WIDTH-1:0] m_axis_tdata, // token_start, token_length
  output logic                                   m_axis_tlast   // last_of_run
);
  import tts_pkg::*;

  logic      in_fire;
  tok_push_t push;
  token_t    out_tok;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // scanner state and per-byte token decisions
  tts_lexer_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .text_byte_i   (s_axis_tdata),
    .end_of_text_i (s_axis_tlast),
    .push_o        (push)
  );

  // result slots, drained one token per cycle while m_axis_tready is high
  tts_token_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_fire),
    .push_data_i  (push),
    .push_ready_o (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_token_o  (out_tok),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_tok.length, out_tok.start};

  // a byte never yields more than two tokens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (push.count != 2'd3))
    else $error("more than two tokens from one byte");

  // a two-token byte shows its first token as not last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (push.count == 2'd2) |=> m_axis_tvalid && !m_axis_tlast)
    else $error("first of two tokens marked last");

  // a byte without tokens leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (push.count == 2'd0) |=> !m_axis_tvalid)
    else $error("token shown for a byte that closed none");

  // reported lengths are never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:16] != 16'd0))
    else $error("zero token length");

endmodule
